@@ hw/rtl/ptree_pkg.sv @@
package ptree_pkg;

    localparam int MAX_TEXT_DEF = 1024;
    localparam int ALPHABET_DEF = 26;

    localparam int LETTER_W = 5;
    localparam int OUT_W    = 11;

    localparam logic [OUT_W-1:0] CNT_MAX = '1;

endpackage

@@ hw/rtl/ptree_ram.sv @@
module ptree_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/palindromic_tree_insert.sv @@
// Steps: an ignored letter goes through S_REP to S_OUT; otherwise each fail-link node
// visited takes S_NODE and S_LEN, plus S_TXT when the text is read, and a created
// node adds S_CHK2 after the second walk for its fail link.
// Throughput: one letter at a time; in_ready returns with the result, and a held
// result stalls the next request in S_OUT until out_ready.
// Reset: async active low; child memory then swept before the first request is taken.
module palindromic_tree_insert #(
    parameter int MAX_TEXT = ptree_pkg::MAX_TEXT_DEF,
    parameter int ALPHABET = ptree_pkg::ALPHABET_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptree_pkg::LETTER_W-1:0] letter,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptree_pkg::OUT_W-1:0]   suffix_node,
    output logic [ptree_pkg::OUT_W-1:0]   suffix_length,
    output logic                          node_created,
    output logic [ptree_pkg::OUT_W-1:0]   end_count,
    output logic                          overflow
);

    import ptree_pkg::*;

    localparam int NODE_DEPTH = MAX_TEXT + 2;
    localparam int NW         = $clog2(NODE_DEPTH);
    localparam int TW         = $clog2(MAX_TEXT + 1);
    localparam int LW         = TW + 1;
    localparam int CD         = NODE_DEPTH * ALPHABET;
    localparam int CAW        = $clog2(CD);
    localparam int NWORD      = LW + NW + OUT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NODE, S_LEN, S_TXT, S_FOUND,
        S_CHK, S_CHK2, S_CNT, S_REP, S_OUT
    } state_t;

    state_t                state_reg;
    logic [CAW-1:0]        clr_reg;
    logic [TW-1:0]         tl_reg;
    logic [NW-1:0]         total_reg;
    logic [NW-1:0]         cur_reg;
    logic [NW-1:0]         x_reg;
    logic [NW-1:0]         now_reg;
    logic [NW-1:0]         now_fail_reg;
    logic [NW-1:0]         fail_reg;
    logic signed [LW-1:0]  now_len_reg;
    logic signed [LW-1:0]  len_reg;
    logic [LETTER_W-1:0]   letter_reg;
    logic                  walk2_reg;
    logic                  ovf_reg;
    logic [OUT_W-1:0]      res_node_reg;
    logic [OUT_W-1:0]      res_len_reg;
    logic [OUT_W-1:0]      res_cnt_reg;
    logic                  res_cre_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      suffix_node_reg;
    logic [OUT_W-1:0]      suffix_length_reg;
    logic [OUT_W-1:0]      end_count_reg;
    logic                  node_created_reg;
    logic                  overflow_reg;

    logic                  node_we;
    logic [NW-1:0]         node_addr;
    logic [NWORD-1:0]      node_wdata;
    logic [NWORD-1:0]      node_rdata;
    logic                  text_we;
    logic [TW-1:0]         text_addr;
    logic [LETTER_W-1:0]   text_rdata;
    logic                  child_we;
    logic [CAW-1:0]        child_addr;
    logic [NW-1:0]         child_wdata;
    logic [NW-1:0]         child_rdata;

    logic signed [LW-1:0]  rd_len;
    logic [NW-1:0]         rd_fail;
    logic [OUT_W-1:0]      rd_cnt;
    logic [OUT_W-1:0]      rd_cnt_inc;
    logic [TW-1:0]         len_u;
    logic                  len_fits;
    logic [CAW-1:0]        slot_x;
    logic [CAW-1:0]        slot_now;
    logic [NW-1:0]         new_node;
    logic signed [LW-1:0]  new_len;
    logic                  accept;
    logic                  out_free;

    assign rd_len     = $signed(node_rdata[NWORD-1 -: LW]);
    assign rd_fail    = node_rdata[OUT_W +: NW];
    assign rd_cnt     = node_rdata[OUT_W-1:0];
    assign rd_cnt_inc = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + OUT_W'(1);
    assign len_u      = rd_len[TW-1:0];
    // pos = tl - len - 1 must be at least 1
    assign len_fits   = ({1'b0, len_u} + (TW+1)'(2)) <= {1'b0, tl_reg};
    assign slot_x     = CAW'(x_reg) * CAW'(ALPHABET) + CAW'(letter_reg);
    assign slot_now   = CAW'(now_reg) * CAW'(ALPHABET) + CAW'(letter_reg);
    assign new_node   = total_reg + NW'(1);
    assign new_len    = now_len_reg + LW'(2);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        node_we     = 1'b0;
        node_addr   = x_reg;
        node_wdata  = '0;
        text_we     = 1'b0;
        text_addr   = tl_reg + TW'(1);
        child_we    = 1'b0;
        child_addr  = slot_x;
        child_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                child_we   = 1'b1;
                child_addr = clr_reg;
                if (clr_reg < CAW'(2))
                begin
                    node_we   = 1'b1;
                    node_addr = clr_reg[NW-1:0];
                    // node0: length 0, fail 1; node1: length -1, fail 0
                    node_wdata = clr_reg[0] ? {{LW{1'b1}}, NW'(0), OUT_W'(0)}
                                            : {LW'(0), NW'(1), OUT_W'(0)};
                end
            end
            S_IDLE:
            begin
                node_addr = cur_reg;
                text_we   = in_valid && (tl_reg != TW'(MAX_TEXT))
                            && (int'(letter) < ALPHABET);
            end
            S_LEN:
            begin
                text_addr = tl_reg - len_u - TW'(1);
            end
            S_CHK:
            begin
                node_addr = child_rdata;
            end
            S_CHK2:
            begin
                node_we     = 1'b1;
                node_addr   = new_node;
                node_wdata  = {new_len, child_rdata, OUT_W'(1)};
                child_we    = 1'b1;
                child_addr  = slot_now;
                child_wdata = new_node;
            end
            S_CNT:
            begin
                node_we    = 1'b1;
                node_addr  = cur_reg;
                node_wdata = {rd_len, rd_fail, rd_cnt_inc};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            tl_reg        <= '0;
            total_reg     <= NW'(1);
            cur_reg       <= '0;
            walk2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CAW'(1);
                    if (clr_reg == CAW'(CD - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        letter_reg <= letter;
                        walk2_reg  <= 1'b0;
                        x_reg      <= cur_reg;
                        if (tl_reg == TW'(MAX_TEXT))
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_REP;
                        end
                        else if (int'(letter) >= ALPHABET)
                        begin
                            ovf_reg   <= 1'b0;
                            state_reg <= S_REP;
                        end
                        else
                        begin
                            ovf_reg   <= 1'b0;
                            tl_reg    <= tl_reg + TW'(1);
                            state_reg <= S_NODE;
                        end
                    end
                end
                S_NODE:
                begin
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    len_reg  <= rd_len;
                    fail_reg <= rd_fail;
                    // the imaginary root always extends
                    if (rd_len < 0)
                    begin
                        state_reg <= S_FOUND;
                    end
                    else if (len_fits)
                    begin
                        state_reg <= S_TXT;
                    end
                    else
                    begin
                        x_reg     <= rd_fail;
                        state_reg <= S_NODE;
                    end
                end
                S_TXT:
                begin
                    if (text_rdata == letter_reg)
                    begin
                        state_reg <= S_FOUND;
                    end
                    else
                    begin
                        x_reg     <= fail_reg;
                        state_reg <= S_NODE;
                    end
                end
                S_FOUND:
                begin
                    if (walk2_reg)
                    begin
                        state_reg <= S_CHK2;
                    end
                    else
                    begin
                        now_reg      <= x_reg;
                        now_len_reg  <= len_reg;
                        now_fail_reg <= fail_reg;
                        state_reg    <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (child_rdata != '0)
                    begin
                        cur_reg     <= child_rdata;
                        res_cre_reg <= 1'b0;
                        state_reg   <= S_CNT;
                    end
                    else
                    begin
                        walk2_reg <= 1'b1;
                        x_reg     <= now_fail_reg;
                        state_reg <= S_NODE;
                    end
                end
                S_CHK2:
                begin
                    cur_reg      <= new_node;
                    total_reg    <= new_node;
                    walk2_reg    <= 1'b0;
                    res_node_reg <= OUT_W'(new_node);
                    res_len_reg  <= OUT_W'(unsigned'(new_len));
                    res_cnt_reg  <= OUT_W'(1);
                    res_cre_reg  <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_CNT:
                begin
                    res_node_reg <= OUT_W'(cur_reg);
                    res_len_reg  <= OUT_W'(unsigned'(rd_len));
                    res_cnt_reg  <= rd_cnt_inc;
                    state_reg    <= S_OUT;
                end
                S_REP:
                begin
                    res_node_reg <= OUT_W'(cur_reg);
                    res_len_reg  <= (rd_len < 0) ? '0 : OUT_W'(unsigned'(rd_len));
                    res_cnt_reg  <= rd_cnt;
                    res_cre_reg  <= 1'b0;
                    state_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        suffix_node_reg   <= res_node_reg;
                        suffix_length_reg <= res_len_reg;
                        end_count_reg     <= res_cnt_reg;
                        node_created_reg  <= res_cre_reg;
                        overflow_reg      <= ovf_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign suffix_node   = suffix_node_reg;
    assign suffix_length = suffix_length_reg;
    assign end_count     = end_count_reg;
    assign node_created  = node_created_reg;
    assign overflow      = overflow_reg;

    ptree_ram #(.WIDTH(NWORD), .DEPTH(NODE_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_wdata),
        .rdata (node_rdata)
    );

    ptree_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_TEXT + 1)) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .addr  (text_addr),
        .wdata (letter),
        .rdata (text_rdata)
    );

    ptree_ram #(.WIDTH(NW), .DEPTH(CD)) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .addr  (child_addr),
        .wdata (child_wdata),
        .rdata (child_rdata)
    );

    // at most one node per stored letter
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(total_reg) <= int'(tl_reg) + 1)
        else $error("node total exceeds text length");

    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= total_reg)
        else $error("current node beyond node total");

    a_created_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && node_created |-> end_count == OUT_W'(1))
        else $error("new node end count not one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("ready right after request");

endmodule
